### hw/rtl/sitoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_pkg
// shared types and constants for the signed integer to radix text converter
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 5;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 8'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CODE = 8'h41;
  localparam logic [CHAR_W-1:0] ERROR_CODE = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  // digit value to its character, 0-9 then A-V
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 5'd10) begin
      return ZERO_CODE + dx;
    end else begin
      return ALPHA_CODE + dx - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sitoa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module sitoa_ram #(
  parameter int WIDTH     = 5,
  parameter int DEPTH     = 32,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/sitoa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_div
// bit-serial restoring divider by a 6-bit radix, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sitoa_div
  import sitoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [RADIX_W-1:0]    divisor,
  output logic                       done,
  output logic      [VALUE_BITS-1:0] quotient,
  output logic      [DIGIT_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [RADIX_W-1:0] dsr;
  logic [RADIX_W-1:0] rem_sh;
  logic               fits;

  // partial remainder stays below the divisor, so 5 bits plus the new bit
  assign rem_sh = {remainder, quotient[VALUE_BITS-1]};
  assign fits   = (rem_sh >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[VALUE_BITS-2:0], fits};
      remainder <= fits ? DIGIT_W'(rem_sh - dsr) : rem_sh[DIGIT_W-1:0];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/signed_integer_to_radix_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_to_radix_ascii
// converts a signed integer to ascii text in radix 2..32, msb character first
// ----------------------------------------------------------------------------
// flow: each digit comes from one pass through the bit-serial divider, then
//   each digit character takes a digit ram read and an output load, and a minus
//   sign, if any, is loaded ahead of the digits
// throughput: one transaction at a time; a bad radix skips the divider
// reset: rst is synchronous, active high; it clears the state machine, the
//   output valid and the divider control; the digit ram is not cleared
// ----------------------------------------------------------------------------
module signed_integer_to_radix_ascii
  import sitoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [VALUE_BITS-1:0] value,
  input  wire logic        [RADIX_W-1:0]    radix,
  // output channel, one transaction per character
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic             [CHAR_W-1:0]     char_code,
  output logic                              is_last,
  output logic                              radix_error
);

  // digit count must hold VALUE_BITS itself, ram index only VALUE_BITS-1
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  state_t state, state_next;

  logic [CNT_W-1:0]      digit_count;
  logic                  negative_flag;
  // radix of the transaction in flight, the input port may move on
  logic [RADIX_W-1:0]    radix_held;

  // divider hookup
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]    div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  quot_zero;

  // digit ram hookup
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DIGIT_W-1:0]    ram_rdata;

  // input side decode
  logic                  radix_ok;
  logic                  value_neg;
  logic [VALUE_BITS-1:0] magnitude;

  // output register load
  logic                  out_free;
  logic                  out_load;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_last;
  logic                  out_err;

  assign radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign value_neg = value[VALUE_BITS-1];
  // two's complement negate; the most negative value wraps to 2^(n-1) itself
  assign magnitude = value_neg ? (VALUE_BITS'(0) - VALUE_BITS'(value))
                               : VALUE_BITS'(value);
  assign quot_zero = (div_quot == '0);
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // first division starts from the magnitude, later ones from the quotient
  assign div_dividend = (state == ST_IDLE) ? magnitude : div_quot;
  // first division takes the radix from the port, later ones the held copy
  assign div_divisor  = (state == ST_IDLE) ? radix : radix_held;

  // digits come back out top first
  assign ram_raddr = ADDR_W'(digit_count - 1'b1);

  // --------------------------------------------------------------------------
  // state register and next state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = radix_ok ? ST_DIV : ST_ERR;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        // keep dividing until the quotient runs out
        if (div_done && quot_zero) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!negative_flag || out_free) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        // ram read data is registered, so it is ready in ST_EMIT
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (digit_count == CNT_W'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // control strobes and output selection
  // --------------------------------------------------------------------------
  always_comb begin
    div_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    out_char  = ERROR_CODE;
    out_last  = 1'b0;
    out_err   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        div_start = in_valid && radix_ok;
      end
      ST_ERR: begin
        out_load = out_free;
        out_char = ERROR_CODE;
        out_last = 1'b1;
        out_err  = 1'b1;
      end
      ST_DIV: begin
        ram_we    = div_done;
        div_start = div_done && !quot_zero;
      end
      ST_SIGN: begin
        out_load = negative_flag && out_free;
        out_char = MINUS_CODE;
      end
      ST_READ: begin
        out_load = 1'b0;
      end
      ST_EMIT: begin
        out_load = out_free;
        out_char = digit_char(ram_rdata);
        out_last = (digit_count == CNT_W'(1));
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // digit count, sign and radix of the transaction in flight
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= '0;
      negative_flag <= 1'b0;
      radix_held    <= '0;
    end else if (state == ST_IDLE && in_valid && radix_ok) begin
      digit_count   <= '0;
      negative_flag <= value_neg;
      radix_held    <= radix;
    end else if (ram_we) begin
      digit_count <= digit_count + 1'b1;
    end else if (state == ST_EMIT && out_load) begin
      digit_count <= digit_count - 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // output register, decouples the character stream from the sink
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_code   <= out_char;
      is_last     <= out_last;
      radix_error <= out_err;
    end
  end

  // --------------------------------------------------------------------------
  // bit-serial divider and digit stack
  // --------------------------------------------------------------------------
  sitoa_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  sitoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (div_rem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire
